// ===== hw/rtl/swswm_pkg.sv =====
package swswm_pkg;

    localparam int IDX_W       = 17;
    localparam int FEAT_W      = 8;
    localparam int GAIN_W      = 12;
    localparam int GAIN_COUNT  = 6;
    localparam int FRAC_BITS   = 8;
    localparam int PROD_W      = FEAT_W + GAIN_W;
    localparam int TERM_W      = PROD_W - FRAC_BITS;
    localparam int SUM_W       = TERM_W + 3;
    localparam int PIX_W       = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int S_TDATA_W   = 72;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 24;

    localparam logic [PIX_W-1:0] PIXEL_MAX = 8'd255;
    localparam logic [PIX_W-1:0] MASK_ON   = 8'd255;
    localparam logic [PIX_W-1:0] MASK_OFF  = 8'd0;

    typedef logic [FEAT_W-1:0] feat_t;
    typedef logic [GAIN_W-1:0] gain_t;
    typedef logic [TERM_W-1:0] term_t;
    typedef logic [PIX_W-1:0]  pix_t;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } op_t;

    localparam gain_t GAIN_RESET [GAIN_COUNT] = '{
        12'd128, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0
    };

endpackage

// ===== hw/rtl/saliency_weighted_sum_winner_mask.sv =====
// An item taken into the input register moves on to the result register, which drives the
// master side directly, so its result can be taken once it sits there.
// Throughput: one item per cycle; products, sum, peak update and store access all sit between
// the input register and the result register, and a master-side stall holds both registers.
// Reset clears the gains to their defaults, the frame peak to 0 and both valids;
// frame store contents are undefined until loaded.
module saliency_weighted_sum_winner_mask #(
    parameter int FRAME_PIXELS = 131072
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [swswm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [swswm_pkg::GAIN_W-1:0]           cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // pixel_index, feature_one .. feature_six, zero pad
    input  logic [swswm_pkg::S_TDATA_W-1:0]        s_axis_tdata,
    // op, frame_start
    input  logic [swswm_pkg::S_TUSER_W-1:0]        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // combined_value, winner_mask, frame_peak
    output logic [swswm_pkg::M_TDATA_W-1:0]        m_axis_tdata
);
    import swswm_pkg::*;

    localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int WIDE_W = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

    // configuration
    gain_t gain_reg [GAIN_COUNT];

    // stage 1: input register
    logic             s1_valid_reg;
    op_t              s1_op_reg;
    logic             s1_start_reg;
    logic [IDX_W-1:0] s1_index_reg;
    feat_t            s1_feat_reg [GAIN_COUNT];

    // stage 2: result register
    logic             s2_valid_reg;
    op_t              s2_op_reg;
    logic             s2_in_range_reg;
    pix_t             s2_sum_reg;
    pix_t             s2_peak_reg;
    logic             s2_load_hit_reg;
    pix_t             rd_data_reg;

    pix_t             peak_reg;
    pix_t             peak_next;

    logic             ready2;
    logic             adv12;

    term_t             term_val [GAIN_COUNT];
    logic [SUM_W-1:0]  sum_raw;
    pix_t              sum_sat;
    logic [WIDE_W-1:0] idx_wide;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    pix_t              out_value;
    pix_t              out_mask;

    pix_t store_mem [FRAME_PIXELS];

    assign ready2        = !s2_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || ready2;
    assign adv12         = s1_valid_reg && ready2;

    always_comb
    begin
        sum_raw = '0;
        for (int i = 0; i < GAIN_COUNT; i++)
        begin
            term_val[i] = TERM_W'((PROD_W'(s1_feat_reg[i]) * PROD_W'(gain_reg[i]))
                                  >> FRAC_BITS);
            sum_raw = sum_raw + SUM_W'(term_val[i]);
        end
        sum_sat = (sum_raw > SUM_W'(PIXEL_MAX)) ? PIXEL_MAX : sum_raw[PIX_W-1:0];
    end

    assign idx_wide = WIDE_W'(s1_index_reg);
    assign in_range = idx_wide < WIDE_W'(FRAME_PIXELS);
    assign addr     = idx_wide[ADDR_W-1:0];

    always_comb
    begin
        peak_next = s1_start_reg ? '0 : peak_reg;
        if (sum_sat > peak_next)
        begin
            peak_next = sum_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GAIN_COUNT; i++)
            begin
                gain_reg[i] <= GAIN_RESET[i];
            end
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            peak_reg     <= '0;
        end
        else
        begin
            for (int i = 0; i < GAIN_COUNT; i++)
            begin
                if (cfg_wr_en && (cfg_index == CFG_IDX_W'(i)))
                begin
                    gain_reg[i] <= cfg_data;
                end
            end
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv12 && (s1_op_reg == OP_LOAD))
            begin
                peak_reg <= peak_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            s1_op_reg    <= op_t'(s_axis_tuser[0]);
            s1_start_reg <= s_axis_tuser[1];
            s1_index_reg <= s_axis_tdata[IDX_W-1:0];
            for (int i = 0; i < GAIN_COUNT; i++)
            begin
                s1_feat_reg[i] <= s_axis_tdata[IDX_W + i*FEAT_W +: FEAT_W];
            end
        end
        if (adv12)
        begin
            s2_op_reg       <= s1_op_reg;
            s2_in_range_reg <= in_range;
            s2_sum_reg      <= sum_sat;
            s2_peak_reg     <= (s1_op_reg == OP_LOAD) ? peak_next : peak_reg;
            s2_load_hit_reg <= (sum_sat == peak_next);
        end
    end

    // frame store: an in-range item leaving stage 1 either writes or reads it, never both
    always_ff @(posedge clk)
    begin
        if (adv12 && in_range)
        begin
            if (s1_op_reg == OP_LOAD)
            begin
                store_mem[addr] <= sum_sat;
            end
            else
            begin
                rd_data_reg <= store_mem[addr];
            end
        end
    end

    always_comb
    begin
        unique case (s2_op_reg)
            OP_LOAD:
            begin
                out_value = s2_sum_reg;
                out_mask  = s2_load_hit_reg ? MASK_ON : MASK_OFF;
            end
            OP_READ:
            begin
                out_value = s2_in_range_reg ? rd_data_reg : '0;
                out_mask  = (s2_in_range_reg && (rd_data_reg == s2_peak_reg)) ?
                            MASK_ON : MASK_OFF;
            end
            default:
            begin
                out_value = '0;
                out_mask  = MASK_OFF;
            end
        endcase
    end

    assign m_axis_tvalid = s2_valid_reg;
    assign m_axis_tdata  = {s2_peak_reg, out_mask, out_value};

    // peak only falls on a frame start
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv12 && (s1_op_reg == OP_LOAD) && !s1_start_reg) |=> (peak_reg >= $past(peak_reg)))
        else $error("frame peak dropped without frame start");

    // a loaded sum never exceeds the peak reported with it
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && (s2_op_reg == OP_LOAD)) |-> (s2_sum_reg <= s2_peak_reg))
        else $error("load result above frame peak");

    // out-of-range reads report zero value and no winner
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && (s2_op_reg == OP_READ) && !s2_in_range_reg)
            |-> (m_axis_tdata[2*PIX_W-1:0] == '0))
        else $error("out-of-range read returned data");

endmodule
